// File: rtl/acbg_pkg.sv
// Shared types, constants and arithmetic helpers of the compute budget governor.
`default_nettype none

package acbg_pkg;

	// Field widths
	localparam int STAMP_W = 32;
	localparam int STEP_BITS = 24;
	localparam int EST_W = STEP_BITS;
	localparam int PORTION_W = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 24;

	// Ticks per second; durations at or above this are ignored
	localparam int TICKS_PER_SECOND = 1000000;

	// Divide by five: multiply by ceil(2^30/5) and shift, exact below 2^30
	localparam int DIV5_IN_W = EST_W + 3;
	localparam int DIV5_OUT_W = DIV5_IN_W - 2;
	localparam int DIV5_SHIFT = DIV5_IN_W + 3;
	localparam int DIV5_RECIP_W = DIV5_SHIFT - 2;
	localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP =
		DIV5_RECIP_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);
	localparam int DIV5_PROD_W = DIV5_IN_W + DIV5_RECIP_W;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MAX = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_IDLE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PORTION = CFG_IDX_W'(3);

	// Reset values of the registers
	localparam logic [EST_W-1:0] RST_BUDGET_MIN = EST_W'(5000);
	localparam logic [EST_W-1:0] RST_BUDGET_MAX = EST_W'(80000);
	localparam logic [EST_W-1:0] RST_BUDGET_IDLE = EST_W'(100000);
	localparam logic [PORTION_W-1:0] RST_MIN_PORTION = PORTION_W'(102);

	typedef enum logic [1:0] {
		OP_INTERACT    = 2'd0,
		OP_SLICE_START = 2'd1,
		OP_SLICE_END   = 2'd2
	} op_t;

	typedef struct packed {
		logic [EST_W-1:0]     budget_min_us;
		logic [EST_W-1:0]     budget_max_us;
		logic [EST_W-1:0]     budget_idle_us;
		logic [PORTION_W-1:0] min_portion_q8;
	} cfg_t;

	typedef struct packed {
		logic [EST_W-1:0] budget_us;
		logic [EST_W-1:0] user_est_us;
		logic [EST_W-1:0] compute_est_us;
	} est_t;

	// Saturate a 32-bit value to the estimate width
	function automatic logic [EST_W-1:0] sat_est(input logic [STAMP_W-1:0] x);
		logic [EST_W-1:0] r;
		if (|x[STAMP_W-1:EST_W]) begin
			r = '1;
		end else begin
			r = x[EST_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DIV5_OUT_W-1:0] div5(input logic [DIV5_IN_W-1:0] x);
		logic [DIV5_PROD_W-1:0] p;
		p = DIV5_PROD_W'(x) * DIV5_PROD_W'(DIV5_RECIP);
		return p[DIV5_SHIFT +: DIV5_OUT_W];
	endfunction

endpackage

`default_nettype wire

// File: rtl/acbg_if.sv
// Channel interfaces: event requests, results and configuration writes.
`default_nettype none

interface acbg_req_if import acbg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [STAMP_W-1:0] stamp_us;

	modport source (output valid, output operation, output stamp_us, input ready);
	modport sink (input valid, input operation, input stamp_us, output ready);
endinterface

interface acbg_res_if import acbg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EST_W-1:0] budget_us;
	logic [EST_W-1:0] user_est_us;
	logic [EST_W-1:0] compute_est_us;

	modport source (output valid, output budget_us, output user_est_us,
		output compute_est_us, input ready);
	modport sink (input valid, input budget_us, input user_est_us,
		input compute_est_us, output ready);
endinterface

interface acbg_cfg_if import acbg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/acbg_cfg.sv
// Configuration register file of the compute budget governor.
`default_nettype none

module acbg_cfg import acbg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	acbg_cfg_if.sink   wr,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign wr.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.budget_min_us <= RST_BUDGET_MIN;
			regs_q.budget_max_us <= RST_BUDGET_MAX;
			regs_q.budget_idle_us <= RST_BUDGET_IDLE;
			regs_q.min_portion_q8 <= RST_MIN_PORTION;
		end else if (wr.valid) begin
			unique case (wr.index)
				REG_BUDGET_MIN: regs_q.budget_min_us <= wr.data[EST_W-1:0];
				REG_BUDGET_MAX: regs_q.budget_max_us <= wr.data[EST_W-1:0];
				REG_BUDGET_IDLE: regs_q.budget_idle_us <= wr.data[EST_W-1:0];
				REG_MIN_PORTION: regs_q.min_portion_q8 <= wr.data[PORTION_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/acbg_core.sv
// Governor state and its combinational update for one event.
`default_nettype none

module acbg_core import acbg_pkg::*; #(
	parameter int TICKS_PER_SEC = TICKS_PER_SECOND
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [1:0]         op,
	input  wire logic [STAMP_W-1:0] stamp,
	input  wire cfg_t               cfg,
	output est_t                    nxt
);

	localparam logic [STAMP_W-1:0] TICKS = STAMP_W'(TICKS_PER_SEC);
	localparam logic [STAMP_W-1:0] ONE = STAMP_W'(1);

	logic [STAMP_W-1:0] inter_q, end_q, start_q;
	logic [EST_W-1:0]   user_q, comp_q, budget_q;

	logic [STAMP_W-1:0] inter_d, end_d, start_d;

	logic [STAMP_W-1:0] d_start_raw, d_start, inter_age, d_end_raw, d_end;
	logic               newer;
	logic [EST_W-1:0]   user_new;
	logic [DIV5_IN_W-1:0] user_x6, scale_in, mavg_in;
	logic [EST_W-1:0]   scaled, floor_v, raised, clamped, budget_new, comp_new;
	logic [STAMP_W-1:0] floor_prod;
	logic               known;

	// Slice start: user estimate
	always_comb begin
		d_start_raw = stamp - end_q;
		d_start = (d_start_raw == '0) ? ONE : d_start_raw;
		inter_age = inter_q - end_q;
		newer = (inter_q != '0) && !inter_age[STAMP_W-1];
		if (newer) begin
			if ((end_q != '0) && (d_start < TICKS)) begin
				user_new = sat_est(d_start);
			end else begin
				user_new = user_q;
			end
		end else if (inter_q != '0) begin
			user_new = sat_est(end_q - inter_q);
		end else begin
			user_new = cfg.budget_idle_us;
		end
	end

	// Slice start: scale, raise to floor, clamp; idle budget while any estimate or the budget is zero
	always_comb begin
		user_x6 = DIV5_IN_W'(user_new) * DIV5_IN_W'(6);
		priority if (DIV5_IN_W'(comp_q) > user_x6) begin
			scale_in = DIV5_IN_W'(budget_q) << 1;
		end else if (comp_q > user_new) begin
			scale_in = DIV5_IN_W'(budget_q) << 2;
		end else begin
			scale_in = DIV5_IN_W'(budget_q) * DIV5_IN_W'(6);
		end
		scaled = sat_est(STAMP_W'(div5(scale_in)));
		floor_prod = STAMP_W'(cfg.min_portion_q8) * STAMP_W'(comp_q);
		floor_v = floor_prod[STAMP_W-1:PORTION_W];
		raised = (scaled < floor_v) ? floor_v : scaled;
		priority if (raised < cfg.budget_min_us) begin
			clamped = cfg.budget_min_us;
		end else if (raised > cfg.budget_max_us) begin
			clamped = cfg.budget_max_us;
		end else begin
			clamped = raised;
		end
		known = (user_new != '0) && (comp_q != '0) && (budget_q != '0);
		budget_new = known ? clamped : cfg.budget_idle_us;
	end

	// Slice end: moving average of compute time
	always_comb begin
		d_end_raw = stamp - start_q;
		d_end = (d_end_raw == '0) ? ONE : d_end_raw;
		mavg_in = DIV5_IN_W'(comp_q) * DIV5_IN_W'(3) + (DIV5_IN_W'(d_end) << 1);
		if (d_end < TICKS) begin
			comp_new = (comp_q == '0) ? sat_est(d_end) :
				sat_est(STAMP_W'(div5(mavg_in)));
		end else begin
			comp_new = comp_q;
		end
	end

	// Select the next state by event
	always_comb begin
		inter_d = inter_q;
		end_d = end_q;
		start_d = start_q;
		nxt.budget_us = budget_q;
		nxt.user_est_us = user_q;
		nxt.compute_est_us = comp_q;
		unique case (op)
			OP_INTERACT: begin
				inter_d = stamp;
			end
			OP_SLICE_START: begin
				start_d = stamp;
				nxt.user_est_us = user_new;
				nxt.budget_us = budget_new;
			end
			OP_SLICE_END: begin
				end_d = stamp;
				nxt.compute_est_us = comp_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inter_q <= '0;
			end_q <= '0;
			start_q <= '0;
			user_q <= '0;
			comp_q <= '0;
			budget_q <= '0;
		end else if (en) begin
			inter_q <= inter_d;
			end_q <= end_d;
			start_q <= start_d;
			user_q <= nxt.user_est_us;
			comp_q <= nxt.compute_est_us;
			budget_q <= nxt.budget_us;
		end
	end

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(budget_q) && $stable(user_q) && $stable(comp_q))
		else $error("governor state moved without an event");

	a_end_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		en && (op == OP_SLICE_END) |=> end_q == $past(stamp))
		else $error("slice end stamp not captured");

	a_interact_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		en && (op == OP_INTERACT) |=> $stable(budget_q) && $stable(comp_q))
		else $error("interaction changed budget or compute estimate");

endmodule

`default_nettype wire

// File: rtl/adaptive_compute_budget_governor_top.sv
// Top level of the adaptive compute budget governor.
//
// Channels: req carries events (operation: interaction, slice start or slice
// end, with a 32-bit microsecond stamp); res returns one result per request
// with the budget, user estimate and compute estimate after that event; cfg
// writes the four registers (index 0 budget_min_us, 1 budget_max_us,
// 2 budget_idle_us, 3 min_portion_q8) and is always ready.
// Pipeline: an input register, update logic that also writes the governor
// state, and a result register. A result shows on res when the result
// register loads it from the input register, which waits while res stalls
// with the result register full.
// Throughput is one request per cycle while res does not stall: the state
// update closes in the same cycle, so the next request sees it at once.
// Reset (arst_n low) clears all stamps, estimates and the budget to zero, loads
// the register defaults and empties both pipeline registers.
// When res stalls, the result register holds its item, one more request is
// taken into the input register, and then req.ready drops until res drains.
`default_nettype none

module adaptive_compute_budget_governor_top import acbg_pkg::*; #(
	parameter int TICKS_PER_SEC = TICKS_PER_SECOND
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	acbg_req_if.sink   req,
	acbg_res_if.source res,
	acbg_cfg_if.sink   cfg
);

	logic               valid_s1, valid_s2;
	logic [1:0]         op_s1;
	logic [STAMP_W-1:0] stamp_s1;
	est_t               res_s2;
	est_t               nxt;
	cfg_t               regs;
	logic               adv;
	logic               req_take;

	// Advance the input register whenever the result register is free or drains
	assign adv = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign req_take = req.valid && req.ready;

	acbg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (regs)
	);

	acbg_core #(
		.TICKS_PER_SEC (TICKS_PER_SEC)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.op     (op_s1),
		.stamp  (stamp_s1),
		.cfg    (regs),
		.nxt    (nxt)
	);

	// Valid bits: hold while stalled, drop once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s1 <= req.operation;
			stamp_s1 <= req.stamp_us;
		end
		if (adv) begin
			res_s2 <= nxt;
		end
	end

	assign res.valid = valid_s2;
	assign res.budget_us = res_s2.budget_us;
	assign res.user_est_us = res_s2.user_est_us;
	assign res.compute_est_us = res_s2.compute_est_us;

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced request left no result");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && !res.ready)
		else $error("request refused while pipeline had room");

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> valid_s1)
		else $error("accepted request not held in input register");

endmodule

`default_nettype wire

// File: tb/acbg_tb_pkg.sv
// Event tracker and report scoreboard for the compute budget governor testbench.
package acbg_tb_pkg;
	import acbg_pkg::*;

	// Operation code outside op_t; the block must leave its state alone
	localparam logic [1:0] OP_IGNORED = 2'd3;
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

	class budget_tracker;
		cfg_t regs;
		logic [STAMP_W-1:0] interact_at;
		logic [STAMP_W-1:0] slice_end_at;
		logic [STAMP_W-1:0] slice_start_at;
		logic [EST_W-1:0] user_est;
		logic [EST_W-1:0] compute_est;
		logic [EST_W-1:0] budget;
		est_t expected_reports[$];
		int unsigned mismatches;

		function new();
			regs.budget_min_us = RST_BUDGET_MIN;
			regs.budget_max_us = RST_BUDGET_MAX;
			regs.budget_idle_us = RST_BUDGET_IDLE;
			regs.min_portion_q8 = RST_MIN_PORTION;
			interact_at = '0;
			slice_end_at = '0;
			slice_start_at = '0;
			user_est = '0;
			compute_est = '0;
			budget = '0;
			mismatches = 0;
		endfunction

		function logic [EST_W-1:0] clip(input logic [63:0] v);
			return (v > 64'hFF_FFFF) ? '1 : v[EST_W-1:0];
		endfunction

		function void write_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BUDGET_MIN: regs.budget_min_us = data[EST_W-1:0];
				REG_BUDGET_MAX: regs.budget_max_us = data[EST_W-1:0];
				REG_BUDGET_IDLE: regs.budget_idle_us = data[EST_W-1:0];
				REG_MIN_PORTION: regs.min_portion_q8 = data[PORTION_W-1:0];
				default: ;
			endcase
		endfunction

		function void open_slice(input logic [STAMP_W-1:0] t);
			logic [STAMP_W-1:0] gap;
			logic [STAMP_W-1:0] lead;
			logic [STAMP_W-1:0] since_touch;
			logic newer;
			logic [63:0] scaled;
			logic [63:0] floor_v;
			logic [63:0] c;
			logic [63:0] u;
			gap = t - slice_end_at;
			if (gap == '0) begin
				gap = 1;
			end
			lead = interact_at - slice_end_at;
			since_touch = slice_end_at - interact_at;
			newer = (interact_at != '0) && !lead[STAMP_W-1];
			if (newer) begin
				if (slice_end_at != '0 && 64'(gap) < 64'(TICKS_PER_SECOND)) begin
					user_est = clip(64'(gap));
				end
			end else if (interact_at != '0) begin
				user_est = clip(64'(since_touch));
			end else begin
				user_est = regs.budget_idle_us;
			end

			u = 64'(user_est);
			c = 64'(compute_est);
			if (user_est == '0 || compute_est == '0 || budget == '0) begin
				budget = regs.budget_idle_us;
			end else begin
				if (c > 6 * u) begin
					scaled = (64'(budget) * 2) / 5;
				end else if (c > u) begin
					scaled = (64'(budget) * 4) / 5;
				end else begin
					scaled = (64'(budget) * 6) / 5;
				end
				scaled = 64'(clip(scaled));
				floor_v = (64'(regs.min_portion_q8) * c) >> 8;
				if (scaled < floor_v) begin
					scaled = floor_v;
				end
				if (scaled < 64'(regs.budget_min_us)) begin
					scaled = 64'(regs.budget_min_us);
				end else if (scaled > 64'(regs.budget_max_us)) begin
					scaled = 64'(regs.budget_max_us);
				end
				budget = clip(scaled);
			end
			slice_start_at = t;
		endfunction

		function void close_slice(input logic [STAMP_W-1:0] t);
			logic [STAMP_W-1:0] dur;
			dur = t - slice_start_at;
			slice_end_at = t;
			if (dur == '0) begin
				dur = 1;
			end
			if (64'(dur) < 64'(TICKS_PER_SECOND)) begin
				if (compute_est == '0) begin
					compute_est = clip(64'(dur));
				end else begin
					compute_est = clip((64'(compute_est) * 3 + 64'(dur) * 2) / 5);
				end
			end
		endfunction

		// Advance the state by one accepted request and queue the report it must produce
		function void note_request(input logic [1:0] op, input logic [STAMP_W-1:0] stamp);
			est_t want;
			case (op)
				OP_INTERACT: interact_at = stamp;
				OP_SLICE_START: open_slice(stamp);
				OP_SLICE_END: close_slice(stamp);
				default: ;
			endcase
			want.budget_us = budget;
			want.user_est_us = user_est;
			want.compute_est_us = compute_est;
			expected_reports.push_back(want);
		endfunction

		function int unsigned outstanding();
			return expected_reports.size();
		endfunction

		function void check_report(input est_t got);
			est_t want;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: unexpected report budget=%0d user=%0d compute=%0d",
						got.budget_us, got.user_est_us, got.compute_est_us);
				end
				return;
			end
			want = expected_reports.pop_front();
			if (got.budget_us !== want.budget_us || got.user_est_us !== want.user_est_us ||
					got.compute_est_us !== want.compute_est_us) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: report mismatch: expected budget=%0d user=%0d compute=%0d",
						want.budget_us, want.user_est_us, want.compute_est_us);
					$display("                        got budget=%0d user=%0d compute=%0d",
						got.budget_us, got.user_est_us, got.compute_est_us);
				end
			end
		endfunction
	endclass
endpackage

// File: tb/adaptive_compute_budget_governor_top_tb.sv
// Testbench of the compute budget governor: directed and random event streams checked by a tracker.
module adaptive_compute_budget_governor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acbg_pkg::*;
	import acbg_tb_pkg::*;

	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 138;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	acbg_req_if req();
	acbg_res_if res();
	acbg_cfg_if cfg();

	adaptive_compute_budget_governor_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg)
	);

	budget_tracker tracker = new();

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned requests_sent;
	logic [STAMP_W-1:0] now_us;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Throttle the result side; a fresh draw every cycle, with no stalls where recv_stall_pct is zero
	always @(negedge clk) begin
		res.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every report taken by the result side against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			tracker.check_report({res.budget_us, res.user_est_us, res.compute_est_us});
		end
	end

	// Offer one request; idle first at random, hold until taken, then note it
	task automatic send_request(input logic [1:0] op, input logic [STAMP_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.operation = op;
		req.stamp_us = stamp;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		tracker.note_request(op, stamp);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop the request side and hold until every report is back and the pipe is empty
	task automatic settle();
		req.valid = 1'b0;
		while (tracker.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = data;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		tracker.write_register(idx, data);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Registers change only with the block idle
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] lo,
			input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] idle,
			input logic [CFG_DATA_W-1:0] portion_word);
		settle();
		write_register(REG_BUDGET_MIN, lo);
		write_register(REG_BUDGET_MAX, hi);
		write_register(REG_BUDGET_IDLE, idle);
		write_register(REG_MIN_PORTION, portion_word);
	endtask

	// Durations: mostly plausible frame times, some zero-ish, some around
	// the one-second cutoff, a few anywhere in the stamp range
	function automatic logic [STAMP_W-1:0] pick_span();
		logic [STAMP_W-1:0] s;
		case ($urandom_range(9))
			0: s = $urandom_range(3);
			1, 2, 3, 4: s = $urandom_range(30000, 1);
			5, 6, 7: s = $urandom_range(300000, 30000);
			8: s = $urandom_range(1100000, 900000);
			default: s = $urandom();
		endcase
		return s;
	endfunction

	// Random part: mostly well-formed frames (optional interaction, slice
	// start, optional interaction while computing, slice end), mixed with
	// missing ends, stray ends and pure noise
	task automatic run_frames(input int unsigned count);
		int unsigned target;
		int unsigned shape;
		logic [STAMP_W-1:0] user_gap;
		logic [STAMP_W-1:0] work;
		target = requests_sent + count;
		while (requests_sent < target) begin
			// jump close to the stamp wrap now and then
			if ($urandom_range(49) == 0) begin
				now_us = 32'hFFFF_FFFF - $urandom_range(300000);
			end
			if ($urandom_range(99) < 12) begin
				send_request(2'($urandom_range(3)),
					($urandom_range(7) == 0) ? '0 : $urandom());
			end else begin
				user_gap = pick_span();
				work = pick_span();
				shape = $urandom_range(3);
				if (shape[0]) begin
					send_request(OP_INTERACT, now_us + $urandom_range(user_gap));
				end
				now_us += user_gap;
				send_request(OP_SLICE_START, now_us);
				if (shape[1]) begin
					send_request(OP_INTERACT, now_us + $urandom_range(work));
				end
				if ($urandom_range(19) != 0) begin
					now_us += work;
					send_request(OP_SLICE_END, now_us);
				end
				if ($urandom_range(29) == 0) begin
					send_request(OP_SLICE_END, now_us + pick_span());
				end
			end
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = OP_INTERACT;
		req.stamp_us = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_BUDGET_MIN;
		cfg.data = '0;
		send_idle_pct = 8;
		recv_stall_pct = 83;
		requests_sent = 0;
		now_us = $urandom();

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset settings
		send_request(OP_SLICE_START, 32'h0000_0000);  // nothing known yet: idle budget
		send_request(OP_SLICE_END, 32'h0000_0000);    // zero length counts as one tick
		send_request(OP_IGNORED, 32'hFFFF_FFFF);
		send_request(OP_INTERACT, 32'hFFFF_FFFF);
		send_request(OP_SLICE_END, 32'h0000_0010);    // interaction now older, across wrap
		send_request(OP_SLICE_START, 32'h0000_0100);
		send_request(OP_SLICE_END, 32'h0000_1500);
		send_request(OP_INTERACT, 32'h8000_0000);
		send_request(OP_SLICE_START, 32'h8000_0010);  // newer interaction, end over a second ago
		send_request(OP_SLICE_END, 32'h8000_0010);
		send_request(OP_INTERACT, 32'h8000_0100);
		send_request(OP_SLICE_START, 32'h8000_0200);  // newer interaction, short user time
		send_request(OP_SLICE_END, 32'h8000_2000);
		send_request(OP_INTERACT, 32'h8000_2001);
		send_request(OP_SLICE_START, 32'h8000_2003);  // compute far above user time
		send_request(OP_SLICE_END, 32'h8010_0000);    // slice of over a second: estimate kept
		send_request(OP_SLICE_END, 32'h8010_0400);    // end with no start in between
		send_request(OP_INTERACT, 32'h0000_0000);     // stamp of zero reads as never
		send_request(OP_SLICE_START, 32'h8020_0000);
		send_request(OP_IGNORED, 32'h5A5A_A5A5);
		send_request(OP_SLICE_START, 32'h8020_0001);
		send_request(OP_SLICE_END, 32'h7FFF_FFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(24'h00_0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'h00_00FF);
				// min above max, idle budget of zero, no floor
				1: apply_settings(24'hFF_FFFF, 24'h00_0000, 24'h00_0000, 24'h00_0000);
				2: apply_settings(24'($urandom_range(20000)), 24'($urandom_range(400000, 20000)),
					24'($urandom_range(200000, 1)), 24'($urandom_range(255)));
				3: begin
					// only the low byte of the portion word counts; unused index is dropped
					apply_settings(24'd1000, 24'd50000, 24'd60000, 24'hABCD_80);
					write_register(REG_UNUSED, 24'h12_3456);
				end
				4: apply_settings(24'd40000, 24'd30000, 24'hFF_FFFF, 24'h00_00FF);
				default: apply_settings(CFG_DATA_W'(RST_BUDGET_MIN), CFG_DATA_W'(RST_BUDGET_MAX),
					CFG_DATA_W'(RST_BUDGET_IDLE), CFG_DATA_W'(RST_MIN_PORTION));
			endcase
			// sender mostly busy then mostly idle, then both sides flat out
			if (phase < 2) begin
				send_idle_pct = 8;
				recv_stall_pct = 83;
			end else if (phase < 4) begin
				send_idle_pct = 83;
				recv_stall_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			run_frames(ITEMS_PER_PHASE);
		end

		settle();
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/acbg_pkg.sv
rtl/acbg_if.sv
rtl/acbg_cfg.sv
rtl/acbg_core.sv
rtl/adaptive_compute_budget_governor_top.sv
tb/acbg_tb_pkg.sv
tb/adaptive_compute_budget_governor_top_tb.sv
